[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// invariant checked every cycle outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

[hw/rtl/chte_pkg.sv]
// ----------------------------------------------------------------------------
// chte_pkg
// shared types, constants and the key mixing function of the hash table engine
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int DEF_BUCKETS    = 256;
  localparam int DEF_WAYS       = 8;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 32;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 12;

  localparam logic [63:0] MIX_MUL   = 64'hff51afd7ed558ccd;
  localparam int          MIX_SHIFT = 33;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_MUL,
    ST_MIX,
    ST_FILL,
    ST_SEARCH,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  // first xor-shift of the mix
  function automatic logic [63:0] mix_pre(input logic [63:0] k);
    mix_pre = k ^ (k >> MIX_SHIFT);
  endfunction

  // final xor-shift of the mix
  function automatic logic [63:0] mix_post(input logic [63:0] h);
    mix_post = h ^ (h >> MIX_SHIFT);
  endfunction

endpackage

[hw/rtl/chte_ram.sv]
// ----------------------------------------------------------------------------
// chte_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/chained_hash_table_engine_top.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top
// key-value hash table with separate chaining over fixed ways per bucket
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (lsb up)            | tuser
// s_axis  | in  | operation, key, value_in         | -
// m_axis  | out | found, value_out, status, count  | -
//
// each request hashes the key, then searches the ways of its bucket in order
// until a hit or the end of the fill; a delete hit moves each later entry
// down one way. a clear op zeroes the fill ram bucket by bucket; after reset
// the fill ram is cleared with tready low and no result beat.
// one result waits in the output register while the next item runs; the
// result step stalls only while that register is still unread.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module chained_hash_table_engine_top import chte_pkg::*; #(
  parameter int BUCKETS    = DEF_BUCKETS,
  parameter int WAYS       = DEF_WAYS,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], key[65:2], value_in[97:66], zero fill
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found[0], value_out[32:1], status[33], entry_count[45:34], zero fill
  output logic [47:0]  m_axis_tdata
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FW    = $clog2(WAYS + 1);
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int SW    = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;

  state_t state, state_next;

  logic [OP_W-1:0]       op;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] val;
  logic [63:0]           h_pre;
  logic [63:0]           p_lo;
  logic [31:0]           p_cross;
  logic [63:0]           h_mul;
  logic [BW-1:0]         bucket;
  logic [BW-1:0]         bucket_calc;
  logic [FW-1:0]         fill;
  logic [FW-1:0]         idx;
  logic                  hit;
  logic [COUNT_W-1:0]    total;
  logic [BW-1:0]         clr_ptr;
  logic                  boot;
  logic                  res_load;
  logic                  out_valid;
  logic                  out_found;
  logic [VAL_W-1:0]      out_value;
  logic                  out_status;
  logic [COUNT_W-1:0]    out_count;

  // ram ports
  logic                  k_we, v_we, f_we;
  logic [SW-1:0]         k_waddr, k_raddr;
  logic [KEY_BITS-1:0]   k_wdata, k_rdata;
  logic [VALUE_BITS-1:0] v_wdata, v_rdata;
  logic [BW-1:0]         f_waddr, f_raddr;
  logic [FW-1:0]         f_wdata, f_rdata;

  chte_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );
  chte_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_vals (
    .clk(clk), .we(v_we), .waddr(k_waddr), .wdata(v_wdata),
    .raddr(k_raddr), .rdata(v_rdata)
  );
  chte_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  function automatic logic [SW-1:0] slot(input logic [BW-1:0] b, input logic [FW-1:0] i);
    logic [31:0] s;
    s = 32'(b) * 32'(WAYS) + 32'(i);
    slot = s[SW-1:0];
  endfunction

  // bucket of the mixed key, also drives the fill read in the mix step
  assign bucket_calc = BW'(mix_post(h_mul) % 64'(BUCKETS));

  // result register loads once the previous beat has gone
  assign res_load = (state == ST_RESULT) && (!out_valid || m_axis_tready);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b0, out_count, out_status, out_value, out_found};

  // ram addressing, write control and next state
  always_comb begin
    k_we    = 1'b0;
    v_we    = 1'b0;
    f_we    = 1'b0;
    k_waddr = slot(bucket, idx);
    k_raddr = slot(bucket, idx);
    k_wdata = key;
    v_wdata = val;
    f_waddr = bucket;
    f_raddr = bucket;
    f_wdata = fill;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_next = (s_axis_tdata[1:0] == OP_CLEAR) ? ST_CLEAR : ST_HASH;
        end
      end
      ST_HASH:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_MIX;
      ST_MIX: begin
        f_raddr    = bucket_calc;
        state_next = ST_FILL;
      end
      ST_FILL:  state_next = ST_SEARCH;
      ST_SEARCH: begin
        // k_rdata holds slot idx-1 once idx > 0
        if (idx != '0 && k_rdata == key) begin
          if (op == OP_INSERT) begin
            v_we    = 1'b1;
            k_waddr = slot(bucket, idx - FW'(1));
            state_next = ST_RESULT;
          end else if (op == OP_DELETE) begin
            f_we    = 1'b1;
            f_wdata = fill - FW'(1);
            k_raddr = slot(bucket, idx);
            state_next = (idx < fill) ? ST_SHIFT_WR : ST_RESULT;
          end else begin
            // keep the hit value on the read port
            k_raddr = slot(bucket, idx - FW'(1));
            state_next = ST_RESULT;
          end
        end else if (idx >= fill) begin
          if (op == OP_INSERT && fill < FW'(WAYS)) begin
            k_we    = 1'b1;
            v_we    = 1'b1;
            k_waddr = slot(bucket, fill);
            f_we    = 1'b1;
            f_wdata = fill + FW'(1);
          end
          state_next = ST_RESULT;
        end
      end
      ST_SHIFT_RD: begin
        k_raddr = slot(bucket, idx);
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        // move slot idx down to idx-1
        k_we    = 1'b1;
        v_we    = 1'b1;
        k_waddr = slot(bucket, idx - FW'(1));
        k_wdata = k_rdata;
        v_wdata = v_rdata;
        state_next = (idx + FW'(1) < fill) ? ST_SHIFT_RD : ST_RESULT;
      end
      ST_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_ptr;
        f_wdata = '0;
        if (clr_ptr == BW'(BUCKETS - 1)) state_next = boot ? ST_IDLE : ST_RESULT;
      end
      ST_RESULT: begin
        // hold the lookup hit value while the output register is busy
        k_raddr = slot(bucket, idx - FW'(1));
        state_next = res_load ? ST_IDLE : ST_RESULT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      clr_ptr <= '0;
      boot    <= 1'b1;
      op      <= OP_CLEAR;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op      <= s_axis_tdata[1:0];
            key     <= s_axis_tdata[2 +: KEY_BITS];
            val     <= s_axis_tdata[66 +: VALUE_BITS];
            h_pre   <= mix_pre(64'(s_axis_tdata[2 +: KEY_BITS]));
            clr_ptr <= '0;
          end
        end
        // low 64 bits of the product from 32x32 partial products
        ST_HASH: begin
          p_lo    <= 64'(h_pre[31:0]) * 64'(MIX_MUL[31:0]);
          p_cross <= h_pre[31:0] * MIX_MUL[63:32];
        end
        ST_MUL: h_mul <= p_lo + {p_cross + h_pre[63:32] * MIX_MUL[31:0], 32'b0};
        ST_MIX: begin
          bucket <= bucket_calc;
          idx    <= '0;
          hit    <= 1'b0;
        end
        ST_FILL: begin
          fill <= (f_rdata > FW'(WAYS)) ? FW'(WAYS) : f_rdata;
          idx  <= '0;
        end
        ST_SEARCH: begin
          if (idx != '0 && k_rdata == key) begin
            hit <= 1'b1;
            if (op == OP_DELETE) begin
              total <= total - COUNT_W'(1);
            end
          end else if (idx >= fill) begin
            if (op == OP_INSERT && fill < FW'(WAYS)) total <= total + COUNT_W'(1);
          end else begin
            idx <= idx + FW'(1);
          end
        end
        ST_SHIFT_WR: idx <= idx + FW'(1);
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + BW'(1);
          if (op == OP_CLEAR) total <= '0;
          if (clr_ptr == BW'(BUCKETS - 1)) boot <= 1'b0;
        end
        ST_RESULT: begin
          if (res_load) begin
            out_found  <= (op != OP_CLEAR) && hit;
            out_value  <= (op == OP_LOOKUP && hit) ? VAL_W'(v_rdata) : '0;
            out_status <= (op == OP_INSERT) && !hit && (fill >= FW'(WAYS));
            out_count  <= total;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, s_axis_tready, state == ST_IDLE, "accept while busy")
  `ASSERT_IMPL(a_fill_bound, clk, rst, state == ST_SEARCH, fill <= FW'(WAYS), "fill over ways")
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, total <= COUNT_W'(SLOTS), "count over slots")

endmodule

[dv/chained_hash_table_engine_top_tb.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top_tb
// streams lookup, insert, delete and clear requests into the hash table
// engine with random gaps on both sides and checks every result beat
// against a behavioral copy of the table kept in the testbench
// ----------------------------------------------------------------------------
module chained_hash_table_engine_top_tb;
  import chte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBKT = DEF_BUCKETS;
  localparam int NWAY = DEF_WAYS;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] value_in;
    logic [63:0] key;
    op_t         operation;
  } request_t;

  typedef struct packed {
    logic [11:0] entry_count;
    logic        status;
    logic [31:0] value_out;
    logic        found;
  } answer_t;

  logic          clk;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [47:0]   m_axis_tdata;

  // behavioral table
  logic [63:0] tbl_key [NBKT][NWAY];
  logic [31:0] tbl_val [NBKT][NWAY];
  int          tbl_fill [NBKT];
  int          tbl_total;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  logic [63:0] live_keys[$];
  int  mismatches;
  int  cycle_count;
  bit  idle_enable;
  bit  beat_taken;
  int  hold_off;
  int  send_gap;
  int  recv_gap;

  chained_hash_table_engine_top DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int bucket_index(logic [63:0] k);
    logic [63:0] h;
    h = k ^ (k >> 33);
    h = h * 64'hff51afd7ed558ccd;
    h = h ^ (h >> 33);
    return int'(h % NBKT);
  endfunction

  // apply one request to the table and return its answer
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int b, i, hit;
    a = '0;
    if (r.operation == OP_CLEAR) begin
      foreach (tbl_fill[j]) tbl_fill[j] = 0;
      tbl_total = 0;
    end else begin
      b = bucket_index(r.key);
      hit = -1;
      for (i = 0; i < tbl_fill[b]; i++)
        if (hit < 0 && tbl_key[b][i] == r.key) hit = i;
      a.found = (hit >= 0);
      case (r.operation)
        OP_LOOKUP: begin
          if (hit >= 0) a.value_out = tbl_val[b][hit];
        end
        OP_INSERT: begin
          if (hit >= 0) tbl_val[b][hit] = r.value_in;
          else if (tbl_fill[b] >= NWAY) a.status = 1'b1;
          else begin
            tbl_key[b][tbl_fill[b]] = r.key;
            tbl_val[b][tbl_fill[b]] = r.value_in;
            tbl_fill[b]++;
            tbl_total++;
          end
        end
        default: begin
          if (hit >= 0) begin
            for (i = hit; i + 1 < tbl_fill[b]; i++) begin
              tbl_key[b][i] = tbl_key[b][i+1];
              tbl_val[b][i] = tbl_val[b][i+1];
            end
            tbl_fill[b]--;
            tbl_total--;
          end
        end
      endcase
    end
    a.entry_count = tbl_total[11:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // keys that all land in one bucket, used to fill it up
  function automatic logic [63:0] key_in_bucket(int b);
    logic [63:0] k;
    do k = rand_key(); while (bucket_index(k) != b);
    return k;
  endfunction

  task automatic push_req(op_t o, logic [63:0] k, logic [31:0] v);
    request_t r;
    r.operation = o; r.key = k; r.value_in = v;
    pending_reqs.push_back(r);
    if (o == OP_INSERT) live_keys.push_back(k);
    if (o == OP_CLEAR) live_keys.delete();
  endtask

  function automatic logic [63:0] pick_key();
    if (live_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return ($urandom_range(0, 3) == 0) ? {48'h0, 16'($urandom)} : rand_key();
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_answers.size() > 0 || s_axis_tvalid)
      @(posedge clk);
  endtask

  // driver: offer the next pending beat, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !beat_taken) begin
      // keep holding the beat
    end else begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        s_axis_tdata <= {6'b0, pending_reqs.pop_front()};
        s_axis_tvalid <= 1'b1;
        if (idle_enable && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready with random stalls and a long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_enable && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 7);
    end
  end

  // monitor: the request is accounted at the accept edge so its answer
  // is in the queue before a result beat can follow it
  always @(posedge clk) begin
    answer_t got, want;
    beat_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (beat_taken) begin
      expected_answers.push_back(apply_request(request_t'(s_axis_tdata[97:0])));
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = answer_t'(m_axis_tdata[45:0]);
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected beat", 64'(got), 64'h0);
      end else begin
        want = expected_answers.pop_front();
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.value_out !== want.value_out)
          report_mismatch("value_out", got.value_out, want.value_out);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int b, n, c;
    logic [63:0] k;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    mismatches = 0; cycle_count = 0; idle_enable = 1'b1;
    hold_off = 0; send_gap = 0; recv_gap = 0;
    tbl_total = 0;
    foreach (tbl_fill[j]) tbl_fill[j] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, all ops, update, full bucket, delete shift and miss
    push_req(OP_LOOKUP, 64'h0, 32'hffffffff);
    push_req(OP_INSERT, 64'h0, 32'hffffffff);
    push_req(OP_INSERT, '1, 32'h0);
    push_req(OP_LOOKUP, 64'h0, 32'h0);
    push_req(OP_LOOKUP, '1, 32'h1234);
    push_req(OP_INSERT, 64'h0, 32'h5a5a5a5a);
    push_req(OP_LOOKUP, 64'h0, 32'h0);
    push_req(OP_DELETE, 64'h12345, 32'h0);
    b = bucket_index(64'h77);
    push_req(OP_INSERT, 64'h77, 32'h77);
    for (int i = 0; i < NWAY; i++) push_req(OP_INSERT, key_in_bucket(b), $urandom);
    push_req(OP_DELETE, 64'h77, 32'h0);
    push_req(OP_INSERT, key_in_bucket(b), 32'h1);
    push_req(OP_LOOKUP, live_keys[live_keys.size() - 2], 32'h0);
    push_req(OP_CLEAR, '1, '1);
    push_req(OP_LOOKUP, 64'h0, 32'h0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    hold_off = 400;
    for (int i = 0; i < 20; i++) push_req(op_t'($urandom_range(0, 2)), pick_key(), $urandom);
    wait_drained();

    // random phase: several rounds of mostly reuse of live keys, some
    // rounds packed into few buckets so that they fill up
    n = 0;
    while (n < 1200) begin
      c = $urandom_range(0, 99);
      if (c < 45) begin
        if ($urandom_range(0, 4) == 0) k = key_in_bucket($urandom_range(0, 3));
        else k = pick_key();
        push_req(OP_INSERT, k, $urandom);
      end else if (c < 75) push_req(OP_LOOKUP, pick_key(), $urandom);
      else if (c < 99) push_req(OP_DELETE, pick_key(), $urandom);
      else push_req(OP_CLEAR, rand_key(), $urandom);
      n++;
      if (n == 900) idle_enable = 1'b0;
      if (pending_reqs.size() > 40) begin
        if (n > 500 && n < 600) wait_drained();
        else while (pending_reqs.size() > 10) @(posedge clk);
      end
    end
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
